// ===== rtl/vertex_coordinate_hash_bits_assert.svh =====
// ----------------------------------------------------------------------------
// vertex_coordinate_hash_bits assertion macros
// shared property forms for the port checker, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef VERTEX_COORDINATE_HASH_BITS_ASSERT_SVH
`define VERTEX_COORDINATE_HASH_BITS_ASSERT_SVH

// same-cycle implication
`define VCHB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vchb: same-cycle check failed");

// next-cycle implication
`define VCHB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vchb: next-cycle check failed");

`endif

// ===== rtl/vchb_pkg.sv =====
// ----------------------------------------------------------------------------
// vchb_pkg
// constants, register map and hash helper functions for the vertex hash block
// ----------------------------------------------------------------------------
package vchb_pkg;

    // fnv-1a 32-bit multiplier
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // byte hashed after each lane index
    localparam logic [7:0] Z_CONST = 8'd28;

    // divisor of the final lane hash
    localparam logic [9:0] Z_DIV = 10'd79;

    // residues of 2^8, 2^16 and 2^24 modulo the divisor
    localparam logic [7:0] RES_B1 = 8'd19;
    localparam logic [7:0] RES_B2 = 8'd45;
    localparam logic [7:0] RES_B3 = 8'd65;

    // default lane count
    localparam int Z_BITS_DEF = 8;

    // register stages from input beat to output register
    localparam int PIPE_DEPTH = 9;

    // apb register map
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_HASH_SEED   = 3'd0;
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd1;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd2;
    localparam logic [2:0] REG_CHUNK_COL   = 3'd3;
    localparam logic [2:0] REG_CHUNK_ROW   = 3'd4;

    // one fnv-1a step over a byte
    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    // fold a 32-bit word to a congruent 16-bit value
    function automatic logic [15:0] fold_word(input logic [31:0] x);
        logic [15:0] s;
        s = 16'(x[7:0])
          + 16'(x[15:8])  * 16'(RES_B1)
          + 16'(x[23:16]) * 16'(RES_B2)
          + 16'(x[31:24]) * 16'(RES_B3);
        return s;
    endfunction

    // fold a 16-bit value twice to a congruent 10-bit value
    function automatic logic [9:0] fold_half(input logic [15:0] y);
        logic [12:0] t;
        logic [9:0]  u;
        t = 13'(y[7:0]) + 13'(y[15:8]) * 13'(RES_B1);
        u = 10'(t[7:0]) + 10'(t[12:8]) * 10'(RES_B1);
        return u;
    endfunction

    // remainder of a 10-bit value by the divisor, binary restoring steps
    function automatic logic [9:0] mod_div(input logic [9:0] v);
        logic [10:0] r;
        r = {1'b0, v};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (11'(Z_DIV) << k))
            begin
                r = r - (11'(Z_DIV) << k);
            end
        end
        return r[9:0];
    endfunction

endpackage

// ===== rtl/vertex_coordinate_hash_bits.sv =====
// The block takes one vertex beat per cycle while in_ready is high and returns
// one z_bits beat for it through nine register stages, the first loaded on the
// accepting edge. The depth is set by the FNV-1a multiply chain (one multiply
// per stage: four coordinate bytes, then two per lane) followed by three stages
// that take the lane hash modulo 79, whose parity with the hash's low bit gives
// the quotient bit. Stages hand beats forward independently, so bubbles close
// up and the input keeps accepting while a finished result waits on the output.
// Configuration is to be written over APB only while the block is idle; the
// block itself does not enforce this. pready is always high.
// ----------------------------------------------------------------------------
// vertex_coordinate_hash_bits
// pipelined fnv-1a coordinate hash producing one quotient-parity bit per lane
// ----------------------------------------------------------------------------
module vertex_coordinate_hash_bits
    import vchb_pkg::*;
#(
    parameter int Z_BITS = Z_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    // vertex channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        vertex_col,
    input  logic [7:0]        vertex_row,

    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        z_bits,

    // apb configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration registers
    logic [31:0] hash_seed_reg;
    logic [7:0]  grid_width_reg;
    logic [7:0]  grid_height_reg;
    logic [7:0]  chunk_col_reg;
    logic [7:0]  chunk_row_reg;

    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg   <= 32'd0;
            grid_width_reg  <= 8'd16;
            grid_height_reg <= 8'd16;
            chunk_col_reg   <= 8'd0;
            chunk_row_reg   <= 8'd0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_HASH_SEED:   hash_seed_reg   <= pwdata;
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[7:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[7:0];
                REG_CHUNK_COL:   chunk_col_reg   <= pwdata[7:0];
                REG_CHUNK_ROW:   chunk_row_reg   <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_HASH_SEED:   prdata = hash_seed_reg;
            REG_GRID_WIDTH:  prdata = {24'd0, grid_width_reg};
            REG_GRID_HEIGHT: prdata = {24'd0, grid_height_reg};
            REG_CHUNK_COL:   prdata = {24'd0, chunk_col_reg};
            REG_CHUNK_ROW:   prdata = {24'd0, chunk_row_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // stage valid bits and per-stage load enables
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] stage_en;

    always_comb
    begin
        stage_en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || out_ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                if (stage_en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // boundary vertex select
    logic       col_edge;
    logic       row_edge;
    logic [7:0] col_local;
    logic [7:0] col_chunk;
    logic [7:0] row_local;
    logic [7:0] row_chunk;

    assign col_edge  = (vertex_col == grid_width_reg);
    assign row_edge  = (vertex_row == grid_height_reg);
    assign col_local = col_edge ? 8'd0 : vertex_col;
    assign col_chunk = col_edge ? 8'(chunk_col_reg + 8'd1) : chunk_col_reg;
    assign row_local = row_edge ? 8'd0 : vertex_row;
    assign row_chunk = row_edge ? 8'(chunk_row_reg + 8'd1) : chunk_row_reg;

    // coordinate hash chain, one byte per stage
    logic [31:0] h1_next;
    logic [31:0] h1_reg;
    logic [7:0]  col_chunk1_reg;
    logic [7:0]  row_local1_reg;
    logic [7:0]  row_chunk1_reg;
    logic [31:0] h2_reg;
    logic [7:0]  row_local2_reg;
    logic [7:0]  row_chunk2_reg;
    logic [31:0] h3_reg;
    logic [7:0]  row_chunk3_reg;
    logic [31:0] h4_reg;

    assign h1_next = fnv_mix(hash_seed_reg, col_local);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            h1_reg         <= h1_next;
            col_chunk1_reg <= col_chunk;
            row_local1_reg <= row_local;
            row_chunk1_reg <= row_chunk;
        end
        if (stage_en[1])
        begin
            h2_reg         <= fnv_mix(h1_reg, col_chunk1_reg);
            row_local2_reg <= row_local1_reg;
            row_chunk2_reg <= row_chunk1_reg;
        end
        if (stage_en[2])
        begin
            h3_reg         <= fnv_mix(h2_reg, row_local2_reg);
            row_chunk3_reg <= row_chunk2_reg;
        end
        if (stage_en[3])
        begin
            h4_reg         <= fnv_mix(h3_reg, row_chunk3_reg);
        end
    end

    // per-lane hash, fold and quotient parity
    logic [Z_BITS-1:0] bits_next;
    logic [Z_BITS-1:0] bits_reg;
    logic [31:0]       bits_ext;

    for (genvar z = 0; z < Z_BITS; z++)
    begin : g_lane
        logic [31:0] mz_reg;
        logic [31:0] mt_reg;
        logic [15:0] fold16_reg;
        logic        par6_reg;
        logic [9:0]  fold10_reg;
        logic        par7_reg;
        logic [9:0]  rem;

        always_ff @(posedge clk)
        begin
            if (stage_en[4])
            begin
                mz_reg <= fnv_mix(h4_reg, 8'(z));
            end
            if (stage_en[5])
            begin
                mt_reg <= fnv_mix(mz_reg, Z_CONST);
            end
            if (stage_en[6])
            begin
                fold16_reg <= fold_word(mt_reg);
                par6_reg   <= mt_reg[0];
            end
            if (stage_en[7])
            begin
                fold10_reg <= fold_half(fold16_reg);
                par7_reg   <= par6_reg;
            end
        end

        // odd divisor: quotient parity is hash parity xor remainder parity
        assign rem          = mod_div(fold10_reg);
        assign bits_next[z] = par7_reg ^ rem[0];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            bits_reg <= bits_next;
        end
    end

    assign bits_ext = 32'(bits_reg);
    assign z_bits   = bits_ext[7:0];

endmodule

// ===== rtl/vchb_checker.sv =====
// ----------------------------------------------------------------------------
// vchb_checker
// port-level checks for the vertex hash block, bound to the top level
// ----------------------------------------------------------------------------
`include "vertex_coordinate_hash_bits_assert.svh"

module vchb_checker
    import vchb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [7:0]        z_bits,
    input logic              psel,
    input logic              pready
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // beats in flight between the two channels
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_beat && !out_beat)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (out_beat && !in_beat)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // a stalled result holds
    `VCHB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(z_bits))

    // input only backs up when every stage is full and the output is stalled
    `VCHB_ASSERT_NOW(a_full_stall, !in_ready, out_valid && !out_ready)

    // no result without an accepted vertex behind it
    `VCHB_ASSERT_NOW(a_no_phantom, out_valid, cnt_reg != '0)

    // never more beats in flight than stages
    `VCHB_ASSERT_NOW(a_depth, 1'b1, cnt_reg <= CNT_W'(PIPE_DEPTH))

    // apb never waits
    `VCHB_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind vertex_coordinate_hash_bits vchb_checker u_vchb_checker (.*);

// ===== verif/vertex_coordinate_hash_bits_checker.sv =====
// ----------------------------------------------------------------------------
// vertex_coordinate_hash_bits_checker
// watches the vertex, result and apb channels, keeps a shadow copy of the
// registers, predicts z_bits for every accepted vertex beat and compares it
// in order with every accepted result beat
// ----------------------------------------------------------------------------
module vertex_coordinate_hash_bits_checker
    import vchb_pkg::*;
#(
    parameter int LANES = Z_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    // vertex channel
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        vertex_col,
    input  logic [7:0]        vertex_row,

    // result channel
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        z_bits,

    // apb configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,

    // end of run, report anything still waiting
    input  logic              finish_check,

    output int                result_count,
    output int                fail_count
);

    // shadow registers
    logic [31:0] seed_q;
    logic [7:0]  width_q;
    logic [7:0]  height_q;
    logic [7:0]  chunk_col_q;
    logic [7:0]  chunk_row_q;

    // predicted z_bits, oldest first
    logic [7:0]  expected_z_q [$];
    bit          leftover_seen;

    // one fnv-1a round over a byte
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    // coordinate hash, then one quotient-parity bit per lane
    function automatic logic [7:0] predict_z_bits(input logic [7:0] col, input logic [7:0] row);
        logic [7:0]  col_local;
        logic [7:0]  col_chunk;
        logic [7:0]  row_local;
        logic [7:0]  row_chunk;
        logic [31:0] h;
        logic [31:0] lane_h;
        logic [31:0] quot;
        logic [31:0] lane_bits;
        int          z;
        col_local = col;
        col_chunk = chunk_col_q;
        row_local = row;
        row_chunk = chunk_row_q;
        // boundary vertex belongs to the next chunk at local index 0
        if (col == width_q)
        begin
            col_local = 8'd0;
            col_chunk = chunk_col_q + 8'd1;
        end
        if (row == height_q)
        begin
            row_local = 8'd0;
            row_chunk = chunk_row_q + 8'd1;
        end
        h = fnv_step(seed_q, col_local);
        h = fnv_step(h, col_chunk);
        h = fnv_step(h, row_local);
        h = fnv_step(h, row_chunk);
        lane_bits = '0;
        for (z = 0; z < LANES && z < 32; z++)
        begin
            lane_h = fnv_step(h, 8'(z));
            lane_h = fnv_step(lane_h, Z_CONST);
            quot = lane_h / 32'(Z_DIV);
            lane_bits[z] = quot[0];
        end
        return lane_bits[7:0];
    endfunction

    // register writes land on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_q      <= 32'd0;
            width_q     <= 8'd16;
            height_q    <= 8'd16;
            chunk_col_q <= 8'd0;
            chunk_row_q <= 8'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[ADDR_W-1:2])
                REG_HASH_SEED:   seed_q      <= pwdata;
                REG_GRID_WIDTH:  width_q     <= pwdata[7:0];
                REG_GRID_HEIGHT: height_q    <= pwdata[7:0];
                REG_CHUNK_COL:   chunk_col_q <= pwdata[7:0];
                REG_CHUNK_ROW:   chunk_row_q <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // in-order compare of result beats against predictions
    always @(posedge clk or negedge rst_n)
    begin : stream_check
        int         errs;
        logic [7:0] exp_z;
        errs = 0;
        if (!rst_n)
        begin
            expected_z_q.delete();
            leftover_seen = 1'b0;
            result_count <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_z_q.size() == 0)
                begin
                    $error("z_bits: beat with no vertex waiting, expected none, actual %02h",
                           z_bits);
                    errs++;
                end
                else
                begin
                    exp_z = expected_z_q.pop_front();
                    if (z_bits !== exp_z)
                    begin
                        $error("z_bits: expected %02h, actual %02h", exp_z, z_bits);
                        errs++;
                    end
                end
                result_count <= result_count + 1;
            end
            if (in_valid && in_ready)
            begin
                expected_z_q = {expected_z_q, predict_z_bits(vertex_col, vertex_row)};
            end
            // predictions that never got a result
            if (finish_check && !leftover_seen && expected_z_q.size() != 0)
            begin
                $error("z_bits: expected %0d more beats, actual 0", expected_z_q.size());
                errs += expected_z_q.size();
                leftover_seen = 1'b1;
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== verif/vertex_coordinate_hash_bits_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_coordinate_hash_bits_tb
// drives vertex beats and apb register writes into the hash block under
// random sender gaps and receiver stalls, one long receiver hold, and a final
// stretch at full rate; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module vertex_coordinate_hash_bits_tb;
    import vchb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int BATCH_ITEMS = 205;

    // register slots past the map, writes there are dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        vertex_col;
    logic [7:0]        vertex_row;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        z_bits;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              finish_check;
    int                result_count;
    int                fail_count;

    bit         send_idle = 1'b0;
    bit         recv_idle = 1'b0;
    bit         hold_req  = 1'b0;
    bit         hold_done;
    int         stall_left;
    int         hold_left;
    int         cycle_count   = 0;
    int         sent_count    = 0;
    int         setting_count = 1;
    logic [7:0] cur_width;
    logic [7:0] cur_height;

    vertex_coordinate_hash_bits u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .vertex_col (vertex_col),
        .vertex_row (vertex_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .z_bits     (z_bits),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    vertex_coordinate_hash_bits_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_col   (vertex_col),
        .vertex_row   (vertex_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .z_bits       (z_bits),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .finish_check (finish_check),
        .result_count (result_count),
        .fail_count   (fail_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("vertex_coordinate_hash_bits: mismatch");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // apb write: setup beat then access beat
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // load every grid register
    task automatic program_grid(input logic [31:0] seed, input logic [7:0] w,
                                input logic [7:0] h, input logic [7:0] cc,
                                input logic [7:0] cr);
        apb_write(REG_HASH_SEED, seed);
        apb_write(REG_GRID_WIDTH, {24'd0, w});
        apb_write(REG_GRID_HEIGHT, {24'd0, h});
        apb_write(REG_CHUNK_COL, {24'd0, cc});
        apb_write(REG_CHUNK_ROW, {24'd0, cr});
        cur_width  = w;
        cur_height = h;
        setting_count++;
    endtask

    // one vertex beat, with an optional gap ahead of it
    task automatic send_vertex(input logic [7:0] c, input logic [7:0] r);
        int gap;
        if (send_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        vertex_col <= c;
        vertex_row <= r;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    // let the pipeline empty before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (result_count != sent_count) @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    // mostly in-grid vertices, boundary often, a little off-grid noise
    task automatic random_batch(input int count);
        logic [7:0] c;
        logic [7:0] r;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 15);
            c = 8'($urandom_range(0, cur_width));
            r = 8'($urandom_range(0, cur_height));
            if (pick == 0)
            begin
                c = 8'($urandom);
                r = 8'($urandom);
            end
            else if (pick <= 2)
            begin
                c = cur_width;
            end
            else if (pick == 3)
            begin
                r = cur_height;
            end
            else if (pick == 4)
            begin
                c = cur_width;
                r = cur_height;
            end
            send_vertex(c, r);
        end
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        vertex_col   = 8'd0;
        vertex_row   = 8'd0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = 32'd0;
        finish_check = 1'b0;
        cur_width    = 8'd16;
        cur_height   = 8'd16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: interior, boundary edges and corner, off-grid
        send_vertex(8'd0, 8'd0);
        send_vertex(8'd16, 8'd16);
        send_vertex(8'd16, 8'd0);
        send_vertex(8'd0, 8'd16);
        send_vertex(8'd15, 8'd15);
        send_vertex(8'd17, 8'd200);
        send_vertex(8'd255, 8'd255);
        wait_idle();

        // all-ones seed, widest grid, chunk bytes wrap on the boundary
        program_grid(32'hffff_ffff, 8'd255, 8'd255, 8'd255, 8'd255);
        send_vertex(8'd255, 8'd255);
        send_vertex(8'd255, 8'd0);
        send_vertex(8'd0, 8'd255);
        send_vertex(8'd254, 8'd254);
        send_vertex(8'd128, 8'd127);
        wait_idle();

        // narrowest grid
        program_grid(32'h811c_9dc5, 8'd1, 8'd1, 8'h7f, 8'h80);
        send_vertex(8'd0, 8'd0);
        send_vertex(8'd1, 8'd1);
        send_vertex(8'd1, 8'd0);
        send_vertex(8'd0, 8'd1);
        send_vertex(8'd2, 8'd2);
        wait_idle();

        // zero-size grid: index 0 is the boundary
        program_grid(32'd0, 8'd0, 8'd0, 8'd3, 8'd200);
        send_vertex(8'd0, 8'd0);
        send_vertex(8'd0, 8'd5);
        send_vertex(8'd9, 8'd0);
        wait_idle();

        // writes past the register map leave the settings alone
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        send_vertex(8'd0, 8'd0);
        send_vertex(8'd1, 8'd1);
        wait_idle();

        // random phases
        for (int ph = 0; ph < 6; ph++)
        begin
            // full-rate sender in the hold phase, no idling in the closing stretch
            send_idle <= (ph != 2) && (ph != 5);
            recv_idle <= (ph != 5);
            case (ph)
                0: program_grid($urandom, 8'd255, 8'd255, 8'($urandom), 8'($urandom));
                1: program_grid($urandom, 8'd1, 8'd1, 8'd255, 8'd255);
                2:
                begin
                    // sender at full rate into a long receiver hold
                    hold_req  <= 1'b1;
                    program_grid($urandom, 8'($urandom_range(1, 255)),
                                 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom));
                end
                3: program_grid($urandom, 8'($urandom_range(1, 255)),
                                8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom));
                4: program_grid($urandom, 8'($urandom_range(0, 8)),
                                8'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
                default:
                begin
                    // closing stretch without idling
                    program_grid($urandom, 8'd255, 8'd255, 8'($urandom), 8'($urandom));
                end
            endcase
            random_batch(BATCH_ITEMS);
            wait_idle();
        end

        finish_check <= 1'b1;
        repeat (2) @(posedge clk);
        $display("run: %0d vertex beats over %0d register settings", sent_count, setting_count);
        $display("run: boundary, chunk wrap, off-grid, zero-size grid, %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("vertex_coordinate_hash_bits: match");
        end
        else
        begin
            $display("vertex_coordinate_hash_bits: mismatch");
        end
        $finish;
    end

endmodule
